/* hdl/lpr_pkg.sv */
// Shared types and constants for the longest-prefix route lookup block.
// No dependencies; compiled first.
package lpr_pkg;

	localparam int LPR_TABLE_DEPTH = 1024;
	localparam int LPR_ADDR_W      = 32;
	localparam int LPR_PORT_W      = 4;
	localparam int LPR_SLOT_W      = 10;
	localparam int LPR_COUNT_W     = 11;

	localparam logic LPR_CMD_WRITE  = 1'b0;
	localparam logic LPR_CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic [LPR_ADDR_W-1:0] prefix;
		logic [LPR_ADDR_W-1:0] mask;
		logic [LPR_ADDR_W-1:0] gateway;
		logic [LPR_PORT_W-1:0] port;
	} route_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} lpr_state_t;

endpackage

/* hdl/lpr_if.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on lpr_pkg for field widths.
interface lpr_req_if;
	import lpr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic [LPR_SLOT_W-1:0]  entry_index;
	logic [LPR_ADDR_W-1:0]  route_prefix;
	logic [LPR_ADDR_W-1:0]  route_mask;
	logic [LPR_ADDR_W-1:0]  route_next_hop;
	logic [LPR_PORT_W-1:0]  route_port;
	logic [LPR_ADDR_W-1:0]  dest_addr;

	modport source (
		output valid, cmd, entry_index, route_prefix, route_mask, route_next_hop,
		       route_port, dest_addr,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, route_prefix, route_mask, route_next_hop,
		       route_port, dest_addr,
		output ready
	);
endinterface

interface lpr_rsp_if;
	import lpr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [LPR_SLOT_W-1:0]  match_index;
	logic [LPR_ADDR_W-1:0]  next_hop_out;
	logic [LPR_PORT_W-1:0]  port_out;

	modport source (
		output valid, found, match_index, next_hop_out, port_out,
		input  ready
	);
	modport sink (
		input  valid, found, match_index, next_hop_out, port_out,
		output ready
	);
endinterface

/* hdl/lpr_mem.sv */
// Route table memory: one write port, one read port, registered read data.
// Depends on lpr_pkg (route_entry_t).
module lpr_mem #(
	parameter int TABLE_DEPTH = lpr_pkg::LPR_TABLE_DEPTH
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
	input  lpr_pkg::route_entry_t              wr_data,
	input  logic                               rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
	output lpr_pkg::route_entry_t              rd_data
);
	import lpr_pkg::*;

	route_entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/lpr_scan.sv */
// Command sequencer: table writes, linear longest-mask scan, response register.
// Depends on lpr_pkg, lpr_if and lpr_mem.
module lpr_scan #(
	parameter int TABLE_DEPTH = lpr_pkg::LPR_TABLE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]   limit,
	lpr_req_if.sink                            req,
	lpr_rsp_if.source                          rsp
);
	import lpr_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	lpr_state_t          state_q, state_d;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	route_entry_t        ent_s1;

	logic [LPR_ADDR_W-1:0] dest_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [LPR_ADDR_W-1:0] best_mask_q;
	logic [LPR_ADDR_W-1:0] best_hop_q;
	logic [LPR_PORT_W-1:0] best_port_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [LPR_SLOT_W-1:0] out_idx_q;
	logic [LPR_ADDR_W-1:0] out_hop_q;
	logic [LPR_PORT_W-1:0] out_port_q;

	logic                accept;
	logic                is_lookup;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	route_entry_t        wr_data;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                hit;
	logic                take;
	logic                out_load;

	assign accept    = req.valid && req.ready;
	assign is_lookup = (req.cmd == LPR_CMD_LOOKUP);

	// Writes only land in idle, so a read never overlaps a write to the same slot.
	assign wr_en   = accept && !is_lookup && (32'(req.entry_index) < 32'(TABLE_DEPTH));
	assign wr_addr = IDX_W'(req.entry_index);
	assign wr_data = '{prefix:   req.route_prefix,
	                   mask:     req.route_mask,
	                   gateway:  req.route_next_hop,
	                   port:     req.route_port};

	lpr_mem #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ent_s1)
	);

	// later slot wins on equal mask
	assign hit  = ((dest_q & ent_s1.mask) == ent_s1.prefix);
	assign take = vld_s1 && hit && (!found_q || (ent_s1.mask >= best_mask_q));

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = rd_idx_q[IDX_W-1:0];
		out_load = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				// ready is high here, so valid alone marks the beat
				if (req.valid) begin
					if (is_lookup && (limit != '0)) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (rd_idx_q < limit) begin
					rd_en = 1'b1;
				end else if (!vld_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (accept) begin
				rd_idx_q <= CNT_W'(1);
				found_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (accept) begin
			dest_q      <= req.dest_addr;
			best_idx_q  <= '0;
			best_mask_q <= '0;
			best_hop_q  <= '0;
			best_port_q <= '0;
		end else if (take) begin
			best_idx_q  <= idx_s1;
			best_mask_q <= ent_s1.mask;
			best_hop_q  <= ent_s1.gateway;
			best_port_q <= ent_s1.port;
		end
		if (out_load) begin
			out_found_q <= found_q;
			out_idx_q   <= LPR_SLOT_W'(best_idx_q);
			out_hop_q   <= best_hop_q;
			out_port_q  <= best_port_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.match_index  = out_idx_q;
	assign rsp.next_hop_out = out_hop_q;
	assign rsp.port_out     = out_port_q;

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CNT_W'(idx_s1) < limit))
		else $error("scan read beyond active route count");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !vld_s1)
		else $error("read data still in flight while idle");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!vld_s1 && !rd_en))
		else $error("table write overlaps a scan read");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |->
			(out_idx_q == '0 && out_hop_q == '0 && out_port_q == '0))
		else $error("miss or write response carries nonzero fields");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("response beat lost at finish");

endmodule

/* hdl/longest_prefix_route_lookup_top.sv */
// Top level of the IPv4 longest-prefix route lookup: route_count register and scan engine.
// Depends on lpr_pkg, lpr_if, lpr_mem and lpr_scan.
//
//  channel   dir  handshake         payload
//  req       in   valid/ready       cmd, entry_index, route entry fields, dest_addr
//  rsp       out  valid/ready       found, match_index, next_hop_out, port_out
//  cfg       in   cfg_we            cfg_wdata -> route_count
//
// One beat at a time. A write, or a lookup with a zero count, skips the scan;
// any other lookup scans min(route_count, TABLE_DEPTH) entries through the table
// memory read port, one entry per cycle. Reset clears control state only; table
// entries are undefined until written. A new request is taken as soon as the
// previous one has its response in the output register, even if rsp stalls.
module longest_prefix_route_lookup_top #(
	parameter int TABLE_DEPTH = lpr_pkg::LPR_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lpr_pkg::LPR_COUNT_W-1:0]  cfg_wdata,
	lpr_req_if.sink                          req,
	lpr_rsp_if.source                        rsp
);
	import lpr_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [LPR_COUNT_W-1:0] route_count_q;
	logic [CNT_W-1:0]       limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
		end else if (cfg_we) begin
			route_count_q <= cfg_wdata;
		end
	end

	// count saturates at table depth
	assign limit = (32'(route_count_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
	                                                      : CNT_W'(route_count_q);

	lpr_scan #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.limit  (limit),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
